[sv/gete_pkg.sv]
// ----------------------------------------------------------------------------
// gete_pkg
// Shared types and codes of the graph edge table engine.
// ----------------------------------------------------------------------------
`default_nettype none

package gete_pkg;

  localparam int CMD_W    = 3;
  localparam int NODE_W   = 16;
  localparam int STATUS_W = 2;
  localparam int VALUE_W  = 6;
  localparam int NTOT_W   = 7;
  localparam int ETOT_W   = 9;
  localparam int DEG_W    = 6;
  localparam logic [DEG_W-1:0] DEG_MAX = 6'd63;

  // command codes
  localparam logic [CMD_W-1:0] CMD_ADD_NODE    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ADD_EDGE    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE_NODE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REMOVE_EDGE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DEGREE      = 3'd4;
  localparam logic [CMD_W-1:0] CMD_MAX_DEGREE  = 3'd5;
  localparam logic [CMD_W-1:0] CMD_CLEAR       = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNUSED      = 3'd7;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_REJECT   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

  // datapath operations
  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_IDLE  = 4'd0;
  localparam logic [OP_W-1:0] OP_LATCH = 4'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 4'd2;
  localparam logic [OP_W-1:0] OP_NRD   = 4'd3;
  localparam logic [OP_W-1:0] OP_NCHK  = 4'd4;
  localparam logic [OP_W-1:0] OP_ERD   = 4'd5;
  localparam logic [OP_W-1:0] OP_ECHK  = 4'd6;
  localparam logic [OP_W-1:0] OP_DRD   = 4'd7;
  localparam logic [OP_W-1:0] OP_DWR   = 4'd8;
  localparam logic [OP_W-1:0] OP_ADDN  = 4'd9;
  localparam logic [OP_W-1:0] OP_WA    = 4'd10;
  localparam logic [OP_W-1:0] OP_WB    = 4'd11;
  localparam logic [OP_W-1:0] OP_WE    = 4'd12;
  localparam logic [OP_W-1:0] OP_DELA  = 4'd13;
  localparam logic [OP_W-1:0] OP_DELB  = 4'd14;
  localparam logic [OP_W-1:0] OP_DELN  = 4'd15;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            load;
  } ctl_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             a_eq_b;
    logic             hit_a;
    logic             hit_b;
    logic             free_any;
    logic             dup;
    logic             add_ok;
    logic             incident;
    logic             last_n;
    logic             last_e;
  } sts_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  value;
    logic [NTOT_W-1:0]   node_total;
    logic [ETOT_W-1:0]   edge_total;
  } res_t;

endpackage

`default_nettype wire

[sv/gete_req_if.sv]
// ----------------------------------------------------------------------------
// gete_req_if
// Command channel: valid/ready handshake with command and two node ids.
// ----------------------------------------------------------------------------
`default_nettype none

interface gete_req_if;
  logic                          valid;
  logic                          ready;
  logic [gete_pkg::CMD_W-1:0]    command;
  logic [gete_pkg::NODE_W-1:0]   node_a;
  logic [gete_pkg::NODE_W-1:0]   node_b;

  modport source (output valid, command, node_a, node_b, input ready);
  modport sink   (input valid, command, node_a, node_b, output ready);
endinterface

`default_nettype wire

[sv/gete_rsp_if.sv]
// ----------------------------------------------------------------------------
// gete_rsp_if
// Result channel: valid/ready handshake with status, value and totals.
// ----------------------------------------------------------------------------
`default_nettype none

interface gete_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [gete_pkg::STATUS_W-1:0] status;
  logic [gete_pkg::VALUE_W-1:0]  value;
  logic [gete_pkg::NTOT_W-1:0]   node_total;
  logic [gete_pkg::ETOT_W-1:0]   edge_total;

  modport source (output valid, status, value, node_total, edge_total, input ready);
  modport sink   (input valid, status, value, node_total, edge_total, output ready);
endinterface

`default_nettype wire

[sv/gete_ctrl.sv]
// ----------------------------------------------------------------------------
// gete_ctrl
// Command sequencer: node scan, edge scan, then the table updates.
// ----------------------------------------------------------------------------
`default_nettype none

module gete_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  input  wire logic          out_free,
  input  wire gete_pkg::sts_t sts,
  output logic               req_ready,
  output gete_pkg::ctl_t     ctl
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_DISP  = 5'd1;
  localparam logic [4:0] S_NRD   = 5'd2;
  localparam logic [4:0] S_NCHK  = 5'd3;
  localparam logic [4:0] S_NDONE = 5'd4;
  localparam logic [4:0] S_ERD   = 5'd5;
  localparam logic [4:0] S_ECHK  = 5'd6;
  localparam logic [4:0] S_DRD   = 5'd7;
  localparam logic [4:0] S_DWR   = 5'd8;
  localparam logic [4:0] S_EDONE = 5'd9;
  localparam logic [4:0] S_ADDN  = 5'd10;
  localparam logic [4:0] S_WA    = 5'd11;
  localparam logic [4:0] S_WB    = 5'd12;
  localparam logic [4:0] S_WE    = 5'd13;
  localparam logic [4:0] S_DELA  = 5'd14;
  localparam logic [4:0] S_DELB  = 5'd15;
  localparam logic [4:0] S_DELN  = 5'd16;
  localparam logic [4:0] S_FIN   = 5'd17;

  logic [4:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign req_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    ctl.op     = gete_pkg::OP_IDLE;
    ctl.load   = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          ctl.op     = gete_pkg::OP_LATCH;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        priority if (sts.cmd == gete_pkg::CMD_CLEAR) begin
          ctl.op     = gete_pkg::OP_CLEAR;
          state_next = S_FIN;
        end else if (sts.cmd == gete_pkg::CMD_UNUSED) begin
          state_next = S_FIN;
        end else if (sts.cmd == gete_pkg::CMD_ADD_EDGE && sts.a_eq_b) begin
          state_next = S_FIN;
        end else begin
          state_next = S_NRD;
        end
      end
      S_NRD: begin
        ctl.op     = gete_pkg::OP_NRD;
        state_next = S_NCHK;
      end
      S_NCHK: begin
        ctl.op     = gete_pkg::OP_NCHK;
        state_next = sts.last_n ? S_NDONE : S_NRD;
      end
      S_NDONE: begin
        priority case (sts.cmd)
          gete_pkg::CMD_ADD_NODE:
            state_next = (!sts.hit_a && sts.free_any) ? S_ADDN : S_FIN;
          gete_pkg::CMD_ADD_EDGE:    state_next = S_ERD;
          gete_pkg::CMD_REMOVE_NODE: state_next = sts.hit_a ? S_ERD : S_FIN;
          gete_pkg::CMD_REMOVE_EDGE:
            state_next = (sts.hit_a && sts.hit_b) ? S_ERD : S_FIN;
          default:                   state_next = S_FIN;
        endcase
      end
      S_ERD: begin
        ctl.op     = gete_pkg::OP_ERD;
        state_next = S_ECHK;
      end
      S_ECHK: begin
        ctl.op = gete_pkg::OP_ECHK;
        priority if (sts.incident) begin
          state_next = S_DRD;
        end else if (sts.last_e) begin
          state_next = S_EDONE;
        end else begin
          state_next = S_ERD;
        end
      end
      S_DRD: begin
        ctl.op     = gete_pkg::OP_DRD;
        state_next = S_DWR;
      end
      S_DWR: begin
        ctl.op     = gete_pkg::OP_DWR;
        state_next = sts.last_e ? S_EDONE : S_ERD;
      end
      S_EDONE: begin
        priority case (sts.cmd)
          gete_pkg::CMD_ADD_EDGE:
            state_next = (!sts.dup && sts.add_ok) ? S_WA : S_FIN;
          gete_pkg::CMD_REMOVE_NODE: state_next = S_DELN;
          gete_pkg::CMD_REMOVE_EDGE: state_next = sts.dup ? S_DELA : S_FIN;
          default:                   state_next = S_FIN;
        endcase
      end
      S_ADDN: begin
        ctl.op     = gete_pkg::OP_ADDN;
        state_next = S_FIN;
      end
      S_WA: begin
        ctl.op     = gete_pkg::OP_WA;
        state_next = S_WB;
      end
      S_WB: begin
        ctl.op     = gete_pkg::OP_WB;
        state_next = S_WE;
      end
      S_WE: begin
        ctl.op     = gete_pkg::OP_WE;
        state_next = S_FIN;
      end
      S_DELA: begin
        ctl.op     = gete_pkg::OP_DELA;
        state_next = S_DELB;
      end
      S_DELB: begin
        ctl.op     = gete_pkg::OP_DELB;
        state_next = S_FIN;
      end
      S_DELN: begin
        ctl.op     = gete_pkg::OP_DELN;
        state_next = S_FIN;
      end
      S_FIN: begin
        ctl.load = out_free;
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

[sv/gete_dp.sv]
// ----------------------------------------------------------------------------
// gete_dp
// Node and edge tables, scan registers, counters and result forming.
// Edges are kept as pairs of node slots, which stay fixed while a node lives.
// ----------------------------------------------------------------------------
`default_nettype none

module gete_dp #(
  parameter int MAX_NODES = 64,
  parameter int MAX_EDGES = 256,
  parameter int ID_BITS   = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire gete_pkg::ctl_t              ctl,
  input  wire logic [gete_pkg::CMD_W-1:0]  command,
  input  wire logic [gete_pkg::NODE_W-1:0] node_a,
  input  wire logic [gete_pkg::NODE_W-1:0] node_b,
  output gete_pkg::sts_t                   sts,
  output gete_pkg::res_t                   res
);

  localparam int NIW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int EIW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int IXW = (NIW > EIW) ? NIW : EIW;
  localparam int NCW = $clog2(MAX_NODES + 1);
  localparam int ECW = $clog2(MAX_EDGES + 1);
  localparam int DW  = gete_pkg::DEG_W;

  // tables
  logic [ID_BITS-1:0] ident_mem [MAX_NODES];
  logic [DW-1:0]      deg_mem   [MAX_NODES];
  logic [2*NIW-1:0]   edge_mem  [MAX_EDGES];
  logic [MAX_NODES-1:0] node_used;
  logic [MAX_EDGES-1:0] edge_used;
  logic [NCW-1:0] ncount;
  logic [ECW-1:0] ecount;

  // command and scan registers
  logic [gete_pkg::CMD_W-1:0] cmd;
  logic [ID_BITS-1:0] id_a, id_b;
  logic [IXW-1:0] idx;
  logic [ID_BITS-1:0] ident_q;
  logic [DW-1:0] deg_q;
  logic [NIW-1:0] ea_q, eb_q;
  logic hit_a, hit_b, dup, efree_any;
  logic [NIW-1:0] slot_a, slot_b, free1, free2, oth;
  logic [DW-1:0] deg_a, deg_b, maxdeg;
  logic [1:0] freec;
  logic [EIW-1:0] dup_idx, efree;

  logic [NIW-1:0] idx_n;
  logic [EIW-1:0] idx_e;
  logic [1:0] need;
  logic ent_used, incident, new_a, new_b;
  logic [NIW-1:0] sel_a, sel_b;
  logic node_we, ident_we;
  logic [NIW-1:0] wr_slot;
  logic [ID_BITS-1:0] wr_id;
  logic [DW-1:0] wr_deg;
  logic [NIW-1:0] rd_slot;

  assign idx_n    = idx[NIW-1:0];
  assign idx_e    = idx[EIW-1:0];
  assign new_a    = !hit_a;
  assign new_b    = !hit_b;
  assign sel_a    = hit_a ? slot_a : free1;
  assign sel_b    = hit_b ? slot_b : (hit_a ? free1 : free2);
  assign need     = {1'b0, new_a} + {1'b0, new_b};
  assign ent_used = edge_used[idx_e];
  assign incident = (cmd == gete_pkg::CMD_REMOVE_NODE) && ent_used &&
                    (ea_q == slot_a || eb_q == slot_a);
  assign rd_slot  = (ctl.op == gete_pkg::OP_DRD) ? oth : idx_n;

  always_comb begin
    sts.cmd      = cmd;
    sts.a_eq_b   = (id_a == id_b);
    sts.hit_a    = hit_a;
    sts.hit_b    = hit_b;
    sts.free_any = (freec != 2'd0);
    sts.dup      = dup;
    sts.add_ok   = !(need > freec) && efree_any &&
                   !(hit_a && deg_a == gete_pkg::DEG_MAX) &&
                   !(hit_b && deg_b == gete_pkg::DEG_MAX);
    sts.incident = incident;
    sts.last_n   = (idx == IXW'(MAX_NODES - 1));
    sts.last_e   = (idx == IXW'(MAX_EDGES - 1));
  end

  // node table write port
  always_comb begin
    node_we  = 1'b0;
    ident_we = 1'b0;
    wr_slot  = sel_a;
    wr_id    = id_a;
    wr_deg   = '0;
    unique case (ctl.op)
      gete_pkg::OP_ADDN: begin
        node_we  = 1'b1;
        ident_we = 1'b1;
        wr_slot  = free1;
      end
      gete_pkg::OP_WA: begin
        node_we  = 1'b1;
        ident_we = 1'b1;
        wr_deg   = new_a ? DW'(1) : deg_a + DW'(1);
      end
      gete_pkg::OP_WB: begin
        node_we  = 1'b1;
        ident_we = 1'b1;
        wr_slot  = sel_b;
        wr_id    = id_b;
        wr_deg   = new_b ? DW'(1) : deg_b + DW'(1);
      end
      gete_pkg::OP_DWR: begin
        node_we = 1'b1;
        wr_slot = oth;
        wr_deg  = deg_q - DW'(1);
      end
      gete_pkg::OP_DELA: begin
        node_we = 1'b1;
        wr_slot = slot_a;
        wr_deg  = deg_a - DW'(1);
      end
      gete_pkg::OP_DELB: begin
        node_we = 1'b1;
        wr_slot = slot_b;
        wr_deg  = deg_b - DW'(1);
      end
      default: ;
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    if (node_we) begin
      deg_mem[wr_slot] <= wr_deg;
    end
    if (ident_we) begin
      ident_mem[wr_slot] <= wr_id;
    end
    if (ctl.op == gete_pkg::OP_NRD || ctl.op == gete_pkg::OP_DRD) begin
      deg_q <= deg_mem[rd_slot];
    end
    if (ctl.op == gete_pkg::OP_NRD) begin
      ident_q <= ident_mem[idx_n];
    end
    if (ctl.op == gete_pkg::OP_WE) begin
      edge_mem[efree] <= {sel_a, sel_b};
    end
    if (ctl.op == gete_pkg::OP_ERD) begin
      {ea_q, eb_q} <= edge_mem[idx_e];
    end
  end

  // used bits and totals
  always_ff @(posedge clk) begin
    if (rst) begin
      node_used <= '0;
      edge_used <= '0;
      ncount    <= '0;
      ecount    <= '0;
    end else begin
      unique case (ctl.op)
        gete_pkg::OP_CLEAR: begin
          node_used <= '0;
          edge_used <= '0;
          ncount    <= '0;
          ecount    <= '0;
        end
        gete_pkg::OP_ADDN: begin
          node_used[free1] <= 1'b1;
          ncount <= ncount + NCW'(1);
        end
        gete_pkg::OP_WA: begin
          node_used[sel_a] <= 1'b1;
          ncount <= ncount + NCW'(new_a);
        end
        gete_pkg::OP_WB: begin
          node_used[sel_b] <= 1'b1;
          ncount <= ncount + NCW'(new_b);
        end
        gete_pkg::OP_WE: begin
          edge_used[efree] <= 1'b1;
          ecount <= ecount + ECW'(1);
        end
        gete_pkg::OP_DWR: begin
          edge_used[idx_e] <= 1'b0;
          ecount <= ecount - ECW'(1);
        end
        gete_pkg::OP_DELA: begin
          edge_used[dup_idx] <= 1'b0;
          ecount <= ecount - ECW'(1);
        end
        gete_pkg::OP_DELN: begin
          node_used[slot_a] <= 1'b0;
          ncount <= ncount - NCW'(1);
        end
        default: ;
      endcase
    end
  end

  // command latch, scan index and scan results
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else begin
      unique case (ctl.op)
        gete_pkg::OP_LATCH: idx <= '0;
        gete_pkg::OP_NCHK:  idx <= sts.last_n ? '0 : idx + IXW'(1);
        gete_pkg::OP_ECHK: begin
          if (!incident) begin
            idx <= idx + IXW'(1);
          end
        end
        gete_pkg::OP_DWR:   idx <= idx + IXW'(1);
        default: ;
      endcase
    end
    unique case (ctl.op)
      gete_pkg::OP_LATCH: begin
        cmd       <= command;
        id_a      <= ID_BITS'(node_a);
        id_b      <= ID_BITS'(node_b);
        hit_a     <= 1'b0;
        hit_b     <= 1'b0;
        dup       <= 1'b0;
        efree_any <= 1'b0;
        freec     <= 2'd0;
        maxdeg    <= '0;
      end
      gete_pkg::OP_NCHK: begin
        if (node_used[idx_n]) begin
          if (ident_q == id_a && !hit_a) begin
            hit_a  <= 1'b1;
            slot_a <= idx_n;
            deg_a  <= deg_q;
          end
          if (ident_q == id_b && !hit_b) begin
            hit_b  <= 1'b1;
            slot_b <= idx_n;
            deg_b  <= deg_q;
          end
          if (deg_q > maxdeg) begin
            maxdeg <= deg_q;
          end
        end else begin
          if (freec == 2'd0) begin
            free1 <= idx_n;
          end
          if (freec == 2'd1) begin
            free2 <= idx_n;
          end
          if (freec != 2'd2) begin
            freec <= freec + 2'd1;
          end
        end
      end
      gete_pkg::OP_ECHK: begin
        if (ent_used) begin
          if (hit_a && hit_b && !dup &&
              ((ea_q == slot_a && eb_q == slot_b) ||
               (ea_q == slot_b && eb_q == slot_a))) begin
            dup     <= 1'b1;
            dup_idx <= idx_e;
          end
          if (incident) begin
            oth <= (ea_q == slot_a) ? eb_q : ea_q;
          end
        end else if (!efree_any) begin
          efree_any <= 1'b1;
          efree     <= idx_e;
        end
      end
      default: ;
    endcase
  end

  // result
  always_comb begin
    res.status = gete_pkg::ST_OK;
    res.value  = '0;
    unique case (cmd)
      gete_pkg::CMD_ADD_NODE: begin
        priority if (hit_a) begin
          res.status = gete_pkg::ST_REJECT;
        end else if (freec == 2'd0) begin
          res.status = gete_pkg::ST_FULL;
        end
      end
      gete_pkg::CMD_ADD_EDGE: begin
        priority if (sts.a_eq_b || dup) begin
          res.status = gete_pkg::ST_REJECT;
        end else if (!sts.add_ok) begin
          res.status = gete_pkg::ST_FULL;
        end
      end
      gete_pkg::CMD_REMOVE_NODE: begin
        if (!hit_a) begin
          res.status = gete_pkg::ST_NOTFOUND;
        end
      end
      gete_pkg::CMD_REMOVE_EDGE: begin
        if (!(hit_a && hit_b && dup)) begin
          res.status = gete_pkg::ST_NOTFOUND;
        end
      end
      gete_pkg::CMD_DEGREE: begin
        if (hit_a) begin
          res.value = gete_pkg::VALUE_W'(deg_a);
        end else begin
          res.status = gete_pkg::ST_NOTFOUND;
        end
      end
      gete_pkg::CMD_MAX_DEGREE: res.value = gete_pkg::VALUE_W'(maxdeg);
      gete_pkg::CMD_CLEAR:      res.status = gete_pkg::ST_OK;
      default:                  res.status = gete_pkg::ST_REJECT;
    endcase
    res.node_total = gete_pkg::NTOT_W'(ncount);
    res.edge_total = gete_pkg::ETOT_W'(ecount);
  end

endmodule

`default_nettype wire

[sv/graph_edge_table_engine_core.sv]
// Both tables are scanned for add edge and, when their nodes are found, for remove node and
// remove edge; the other commands scan only the node table, and clear, code 7 and a self
// loop scan neither. Remove node adds a degree read and write per incident edge. Each table
// entry is scanned as a read followed by a check. Throughput: one command at a time,
// accepted from the cycle after the previous result is loaded; a result still waiting for
// its transaction holds the sequencer. Reset: sync.
// ----------------------------------------------------------------------------
// graph_edge_table_engine_core
// Undirected graph kept as node and edge tables, with degree tracking.
// ----------------------------------------------------------------------------
`default_nettype none

module graph_edge_table_engine_core #(
  parameter int MAX_NODES = 64,
  parameter int MAX_EDGES = 256,
  parameter int ID_BITS   = 16
) (
  input wire logic clk,
  input wire logic rst,
  gete_req_if.sink  req,
  gete_rsp_if.source rsp
);

  gete_pkg::ctl_t ctl;
  gete_pkg::sts_t sts;
  gete_pkg::res_t res;
  gete_pkg::res_t rsp_q;
  logic rsp_valid;
  logic out_free;

  assign out_free = !rsp_valid || rsp.ready;

  gete_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .out_free  (out_free),
    .sts       (sts),
    .req_ready (req.ready),
    .ctl       (ctl)
  );

  gete_dp #(
    .MAX_NODES (MAX_NODES),
    .MAX_EDGES (MAX_EDGES),
    .ID_BITS   (ID_BITS)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .command (req.command),
    .node_a  (req.node_a),
    .node_b  (req.node_b),
    .sts     (sts),
    .res     (res)
  );

  // output register: hold the result until its transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctl.load) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
    if (ctl.load) begin
      rsp_q <= res;
    end
  end

  assign rsp.valid      = rsp_valid;
  assign rsp.status     = rsp_q.status;
  assign rsp.value      = rsp_q.value;
  assign rsp.node_total = rsp_q.node_total;
  assign rsp.edge_total = rsp_q.edge_total;

endmodule

`default_nettype wire
